@@ rtl/hex_field_formatter_assert.svh @@
// hex_field_formatter_assert.svh: assertion macros for the hex field formatter
// used by the port checker; depends on nothing, expects i_clk and i_rst_n in scope
`ifndef HEX_FIELD_FORMATTER_ASSERT_SVH
`define HEX_FIELD_FORMATTER_ASSERT_SVH

// same-cycle implication, sampled on the rising clock, off during reset
`define HFF_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("hff check failed");

// next-cycle implication, sampled on the rising clock, off during reset
`define HFF_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("hff check failed");

`endif

@@ rtl/hff_pkg.sv @@
// hff_pkg: shared types, register indexes and character constants
// of the hex field formatter; depends on nothing
package hff_pkg;

    // configuration register indexes
    typedef enum logic [2:0] {
        REG_UPPER_CASE   = 3'd0,
        REG_ALT_FORM     = 3'd1,
        REG_LEFT_JUSTIFY = 3'd2,
        REG_ZERO_FILL    = 3'd3,
        REG_PREC_GIVEN   = 3'd4,
        REG_MIN_DIGITS   = 3'd5,
        REG_FIELD_WIDTH  = 3'd6
    } t_reg_index;

    // controller states
    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_NORM  = 5'b00010,
        S_SIZE  = 5'b00100,
        S_COUNT = 5'b01000,
        S_EMIT  = 5'b10000
    } t_state;

    // configuration as seen by the emitter
    typedef struct packed {
        logic       upper_case;
        logic       alt_form;
        logic       left_justify;
        logic       zero_fill;
        logic       precision_given;
        logic [5:0] min_digits;
        logic [5:0] field_width;
    } t_cfg;

    // commands from the controller to the digit shifter
    typedef struct packed {
        logic load;
        logic step;
        logic shift;
    } t_shift_ctl;

    // status from the digit shifter
    typedef struct packed {
        logic [3:0] nibble;
        logic [3:0] len;
        logic       norm_done;
    } t_shift_sts;

    localparam logic [7:0] CHR_SPACE   = 8'h20;
    localparam logic [7:0] CHR_ZERO    = 8'h30;
    localparam logic [7:0] CHR_X_LOWER = 8'h78;
    localparam logic [7:0] CHR_X_UPPER = 8'h58;
    localparam logic [7:0] CHR_A_LOWER = 8'h61;
    localparam logic [7:0] CHR_A_UPPER = 8'h41;
    localparam logic [3:0] NUM_NIBBLES = 4'd8;

    // ascii of one hex digit
    function automatic logic [7:0] hex_char(input logic [3:0] nib, input logic upper);
        logic [7:0] base;
        base = upper ? CHR_A_UPPER : CHR_A_LOWER;
        if (nib < 4'd10) begin
            hex_char = CHR_ZERO + {4'd0, nib};
        end else begin
            hex_char = base + {4'd0, nib} - 8'd10;
        end
    endfunction

endpackage

@@ rtl/hex_field_formatter.sv @@
// hex_field_formatter: top level of the printf-style hex field formatter
// depends on hff_pkg, hff_digit_shift and hff_emit
//
// Usage:
//   Input channel i_valid / o_ready carries one 32-bit value per item.
//   Output channel o_valid / i_ready carries one ASCII character per item,
//   o_last on the final character with o_char_total giving the field length;
//   an empty field gives a single item with o_no_char and o_last set.
//   Configuration is written through i_cfg_we / i_cfg_index / i_cfg_data
//   while the block is idle; all registers reset to zero.
// Sequencing:
//   After a value is taken, leading zero digits are stripped one per cycle,
//   the S_SIZE and S_COUNT states size the field, then one character per
//   cycle leaves through the output register while the receiver takes them.
//   A new value is taken as soon as the last character is in the output
//   register, so sizing of the next value overlaps a waiting last character.
// Reset and stalls:
//   Synchronous active-low reset empties the output register and returns
//   the controller to idle. A stalled receiver holds the current character
//   and freezes emission until it is taken.
module hex_field_formatter #(
    parameter int MAX_FIELD = 48
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [5:0]  i_cfg_data,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [31:0] i_value,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [7:0]  o_char_code,
    output logic        o_no_char,
    output logic        o_last,
    output logic [5:0]  o_char_total
);
    import hff_pkg::*;

    t_cfg       r_cfg, n_cfg;
    t_shift_ctl shift_ctl;
    t_shift_sts shift_sts;

    // configuration register writes
    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_UPPER_CASE:   n_cfg.upper_case      = i_cfg_data[0];
                REG_ALT_FORM:     n_cfg.alt_form        = i_cfg_data[0];
                REG_LEFT_JUSTIFY: n_cfg.left_justify    = i_cfg_data[0];
                REG_ZERO_FILL:    n_cfg.zero_fill       = i_cfg_data[0];
                REG_PREC_GIVEN:   n_cfg.precision_given = i_cfg_data[0];
                REG_MIN_DIGITS:   n_cfg.min_digits      = i_cfg_data;
                REG_FIELD_WIDTH:  n_cfg.field_width     = i_cfg_data;
                default:          n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    // digit shift register
    hff_digit_shift u_shift (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_value (i_value),
        .i_ctl   (shift_ctl),
        .o_sts   (shift_sts)
    );

    // sizing, sequencing and output register
    hff_emit #(
        .MAX_FIELD (MAX_FIELD)
    ) u_emit (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_sts        (shift_sts),
        .o_ctl        (shift_ctl),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_char_code  (o_char_code),
        .o_no_char    (o_no_char),
        .o_last       (o_last),
        .o_char_total (o_char_total)
    );

endmodule

@@ rtl/hff_digit_shift.sv @@
// hff_digit_shift: nibble shift register that strips leading zero digits
// and then hands out one hex digit per shift; depends on hff_pkg
module hff_digit_shift (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic [31:0]         i_value,
    input  hff_pkg::t_shift_ctl i_ctl,
    output hff_pkg::t_shift_sts o_sts
);
    import hff_pkg::*;

    logic [31:0] r_shift, n_shift;
    logic [3:0]  r_len, n_len;
    logic        norm_done;

    // normalization ends at a nonzero top digit or a single digit left
    assign norm_done = (r_len <= 4'd1) || (r_shift[31:28] != 4'd0);

    // load, strip a leading zero, or move to the next digit
    always_comb begin
        n_shift = r_shift;
        n_len   = r_len;
        if (i_ctl.load) begin
            n_shift = i_value;
            n_len   = NUM_NIBBLES;
        end else if (i_ctl.step && !norm_done) begin
            n_shift = {r_shift[27:0], 4'd0};
            n_len   = r_len - 4'd1;
        end else if (i_ctl.shift) begin
            n_shift = {r_shift[27:0], 4'd0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len <= 4'd0;
        end else begin
            r_len <= n_len;
        end
        r_shift <= n_shift;
    end

    assign o_sts.nibble    = r_shift[31:28];
    assign o_sts.len       = r_len;
    assign o_sts.norm_done = norm_done;

endmodule

@@ rtl/hff_emit.sv @@
// hff_emit: controller that sizes the field, counts out pad, prefix, zeros,
// digits and trailing pad, and holds the output register; depends on hff_pkg
module hff_emit #(
    parameter int MAX_FIELD = 48
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  hff_pkg::t_cfg       i_cfg,
    input  logic                i_valid,
    output logic                o_ready,
    input  hff_pkg::t_shift_sts i_sts,
    output hff_pkg::t_shift_ctl o_ctl,
    output logic                o_valid,
    input  logic                i_ready,
    output logic [7:0]          o_char_code,
    output logic                o_no_char,
    output logic                o_last,
    output logic [5:0]          o_char_total
);
    import hff_pkg::*;

    localparam int CW = ($clog2(MAX_FIELD + 1) > 6) ? $clog2(MAX_FIELD + 1) : 6;
    localparam logic [CW-1:0] PREC_MAX  = CW'(MAX_FIELD - 8);
    localparam logic [CW-1:0] WIDTH_MAX = CW'(MAX_FIELD);
    localparam logic [CW-1:0] PREFIX_LEN = CW'(2);

    t_state r_state, n_state;

    // sizing results
    logic [CW-1:0] r_body, n_body;
    logic [CW-1:0] r_core, n_core;
    logic [CW-1:0] r_width, n_width;
    logic [3:0]    r_len, n_len;
    logic          r_prefix, n_prefix;
    logic          r_zero_pad, n_zero_pad;

    // emission counters
    logic [CW-1:0] r_lead, n_lead;
    logic [1:0]    r_pre, n_pre;
    logic [CW-1:0] r_zeros, n_zeros;
    logic [3:0]    r_digits, n_digits;
    logic [CW-1:0] r_trail, n_trail;
    logic [CW-1:0] r_rem, n_rem;
    logic [CW-1:0] r_tot, n_tot;

    // output register
    logic          r_out_valid, n_out_valid;
    logic [7:0]    r_char, n_char;
    logic          r_no_char, n_no_char;
    logic          r_last, n_last;
    logic [5:0]    r_total, n_total;

    logic          can_load;
    logic          is_zero;
    logic [CW-1:0] len_ext, prec, mind, fw, len_eff, pad;

    assign can_load = !r_out_valid || i_ready;
    assign is_zero  = (i_sts.len == 4'd1) && (i_sts.nibble == 4'd0);
    assign mind     = CW'(i_cfg.min_digits);
    assign fw       = CW'(i_cfg.field_width);
    assign prec     = (mind > PREC_MAX) ? PREC_MAX : mind;
    assign len_ext  = (i_cfg.precision_given && (i_cfg.min_digits == 6'd0) && is_zero)
                      ? '0 : CW'(i_sts.len);
    assign len_eff  = len_ext;
    assign pad      = (r_width > r_core) ? (r_width - r_core) : '0;

    always_comb begin
        n_state     = r_state;
        n_body      = r_body;
        n_core      = r_core;
        n_width     = r_width;
        n_len       = r_len;
        n_prefix    = r_prefix;
        n_zero_pad  = r_zero_pad;
        n_lead      = r_lead;
        n_pre       = r_pre;
        n_zeros     = r_zeros;
        n_digits    = r_digits;
        n_trail     = r_trail;
        n_rem       = r_rem;
        n_tot       = r_tot;
        n_out_valid = r_out_valid && !i_ready;
        n_char      = r_char;
        n_no_char   = r_no_char;
        n_last      = r_last;
        n_total     = r_total;
        o_ready     = 1'b0;
        o_ctl       = '0;

        unique case (r_state)
            // wait for an item and load the shifter
            S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    o_ctl.load = 1'b1;
                    n_state    = S_NORM;
                end
            end
            // strip leading zero digits, one per cycle
            S_NORM: begin
                o_ctl.step = 1'b1;
                if (i_sts.norm_done) begin
                    n_state = S_SIZE;
                end
            end
            // digit count, body, prefix and width
            S_SIZE: begin
                n_len      = len_eff[3:0];
                n_body     = (i_cfg.precision_given && (prec > len_eff)) ? prec : len_eff;
                n_prefix   = i_cfg.alt_form && !is_zero;
                n_core     = n_body + (n_prefix ? PREFIX_LEN : '0);
                n_width    = (fw > WIDTH_MAX) ? WIDTH_MAX : fw;
                n_zero_pad = i_cfg.zero_fill && !i_cfg.precision_given && !i_cfg.left_justify;
                n_state    = S_COUNT;
            end
            // split the padding among its places
            S_COUNT: begin
                n_lead   = (!i_cfg.left_justify && !r_zero_pad) ? pad : '0;
                n_pre    = r_prefix ? 2'd2 : 2'd0;
                n_zeros  = (r_zero_pad ? pad : '0) + (r_body - CW'(r_len));
                n_digits = r_len;
                n_trail  = i_cfg.left_justify ? pad : '0;
                n_rem    = pad + r_core;
                n_tot    = pad + r_core;
                n_state  = S_EMIT;
            end
            // one character per cycle into the output register, while it can take one
            S_EMIT: begin
                if (can_load) begin
                    n_out_valid = 1'b1;
                    n_no_char   = 1'b0;
                    n_last      = (r_rem <= CW'(1));
                    n_total     = (r_rem <= CW'(1)) ? r_tot[5:0] : 6'd0;
                    n_rem       = r_rem - CW'(1);
                    priority if (r_rem == '0) begin
                        n_no_char = 1'b1;
                        n_char    = 8'd0;
                        n_rem     = '0;
                    end else if (r_lead != '0) begin
                        n_char = CHR_SPACE;
                        n_lead = r_lead - CW'(1);
                    end else if (r_pre == 2'd2) begin
                        n_char = CHR_ZERO;
                        n_pre  = 2'd1;
                    end else if (r_pre == 2'd1) begin
                        n_char = i_cfg.upper_case ? CHR_X_UPPER : CHR_X_LOWER;
                        n_pre  = 2'd0;
                    end else if (r_zeros != '0) begin
                        n_char  = CHR_ZERO;
                        n_zeros = r_zeros - CW'(1);
                    end else if (r_digits != 4'd0) begin
                        n_char      = hex_char(i_sts.nibble, i_cfg.upper_case);
                        n_digits    = r_digits - 4'd1;
                        o_ctl.shift = 1'b1;
                    end else begin
                        n_char  = CHR_SPACE;
                        n_trail = r_trail - CW'(1);
                    end
                    if (r_rem <= CW'(1)) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_lead      <= '0;
            r_pre       <= 2'd0;
            r_zeros     <= '0;
            r_digits    <= 4'd0;
            r_trail     <= '0;
            r_rem       <= '0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_lead      <= n_lead;
            r_pre       <= n_pre;
            r_zeros     <= n_zeros;
            r_digits    <= n_digits;
            r_trail     <= n_trail;
            r_rem       <= n_rem;
        end
        r_body     <= n_body;
        r_core     <= n_core;
        r_width    <= n_width;
        r_len      <= n_len;
        r_prefix   <= n_prefix;
        r_zero_pad <= n_zero_pad;
        r_tot      <= n_tot;
        r_char     <= n_char;
        r_no_char  <= n_no_char;
        r_last     <= n_last;
        r_total    <= n_total;
    end

    assign o_valid      = r_out_valid;
    assign o_char_code  = r_char;
    assign o_no_char    = r_no_char;
    assign o_last       = r_last;
    assign o_char_total = r_total;

endmodule

@@ rtl/hff_checker.sv @@
// hff_checker: port-level checks of the hex field formatter and its bind
// depends on hex_field_formatter_assert.svh and the hex_field_formatter ports
`include "hex_field_formatter_assert.svh"

module hff_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_ready,
    input logic        o_valid,
    input logic        i_ready,
    input logic [7:0]  o_char_code,
    input logic        o_no_char,
    input logic        o_last,
    input logic [5:0]  o_char_total
);

    logic empty_ok;

    // what an empty field item must carry
    assign empty_ok = o_last && (o_char_code == 8'd0) && (o_char_total == 6'd0);

    // an empty field is a single, final item with nothing in it
    `HFF_ASSERT_NOW(a_empty_last, o_valid && o_no_char, empty_ok)

    // the length shows only on the final character
    `HFF_ASSERT_NOW(a_total_on_last, o_valid && !o_last, o_char_total == 6'd0)

    // one value at a time: no second value right after one is taken
    `HFF_ASSERT_NEXT(a_one_at_a_time, i_valid && o_ready, !o_ready)

    // a stalled character holds
    `HFF_ASSERT_NEXT(a_out_hold, o_valid && !i_ready, o_valid && $stable(o_char_code) && $stable(o_last))

endmodule

bind hex_field_formatter hff_checker u_hff_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_valid      (i_valid),
    .o_ready      (o_ready),
    .o_valid      (o_valid),
    .i_ready      (i_ready),
    .o_char_code  (o_char_code),
    .o_no_char    (o_no_char),
    .o_last       (o_last),
    .o_char_total (o_char_total)
);
